### hdl/orb_pkg.sv
// ----------------------------------------------------------------------------
// orb_pkg
// shared types and constants of the overlap reblocking buffer
// ----------------------------------------------------------------------------
`default_nettype none

package orb_pkg;

  localparam int CFG_W    = 11;             // width of the length registers
  localparam int SAMPLE_W = 32;             // raw sample word
  localparam int IDX_W    = 3;              // register index
  localparam int CNT_W    = $clog2(CFG_W);  // modulo step counter

  localparam logic [CFG_W-1:0] RST_LEN = 11'd64;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_BUF_LEN   = 3'd0,
    REG_HOP_LEN   = 3'd1,
    REG_WR_START  = 3'd2,
    REG_ZERO_MODE = 3'd3,
    REG_WR_VLEN   = 3'd4,
    REG_RD_VLEN   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_RUN   = 2'd1,
    ST_MOD   = 2'd2
  } seq_state_t;

  // status from the sequencer to the datapath
  typedef struct packed {
    logic             busy;
    logic             clr_we;
    logic             mod_done;
    logic [CFG_W-1:0] mod_rem;
  } seq_stat_t;

endpackage

`default_nettype wire

### hdl/overlap_reblock_buffer.sv
// ----------------------------------------------------------------------------
// overlap_reblock_buffer
// sliding-window reblocking buffer for raw audio sample words
// ----------------------------------------------------------------------------
//
//  channel | ports                     | content
//  --------+---------------------------+--------------------------------------
//  input   | in_tvalid/tready/tdata/   | one write or read of a sample word
//          | tuser                     |
//  output  | out_tvalid/tready/tdata/  | one result per input transfer
//          | tuser                     |
//  config  | cfg_we/cfg_index/cfg_wdata| register writes, no read-back
//
//  one input transfer per cycle while in_tready is high; its result is
//    registered in the ram read stage, then in the output register
//  after reset a clearing pass over all MAX_ENTRIES addresses zeroes the ram,
//    with in_tready low; config writes are taken meanwhile
//  a buffer_length write starts a reduction of the window base
//    modulo the new length, again with in_tready low
//  an output stall holds the ram read stage and then in_tready
//
`default_nettype none

module overlap_reblock_buffer
  import orb_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input stream
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [SAMPLE_W-1:0] in_tdata,   // [31:0] in_sample
  input  wire logic                in_tuser,   // [0] op
  // result stream
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic      [SAMPLE_W-1:0] out_tdata,  // [31:0] out_sample
  output logic                     out_tuser,  // [0] is_read
  // configuration
  input  wire logic                cfg_we,
  input  wire logic [IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata
);

  localparam int AW = $clog2(MAX_ENTRIES);
  // largest usable length, limited by what the 11-bit register can hold
  localparam logic [CFG_W-1:0] MAX_LEN =
    (MAX_ENTRIES > 2047) ? 11'd2047 : CFG_W'(MAX_ENTRIES);

  // configuration registers
  logic [CFG_W-1:0] buf_len_r, hop_len_r, wr_vlen_r, rd_vlen_r;
  logic             zero_mode_r;

  // window state
  logic [CFG_W-1:0] raw_base_r;  // base as last set by a slide
  logic [CFG_W-1:0] rb_r;        // base reduced modulo the current length
  logic [CFG_W-1:0] wpos_r, rpos_r, wcnt_r, rcnt_r;

  // pipeline
  logic                s1_valid_r, s1_ram_r, s1_rd_r;
  logic                out_valid_r, out_rd_r;
  logic [SAMPLE_W-1:0] out_data_r;

  // effective register values
  logic [CFG_W-1:0] len, hop, wlen, rlen;

  logic             accept, is_rd, s1_go, len_wr;
  logic             slide, do_wr, do_rd;
  logic [CFG_W:0]   base_sum, phys_sum;
  logic [CFG_W-1:0] base_slid, wbase, wpos1, base_sel, pos_sel, phys;
  logic [CFG_W-1:0] wcnt1, rcnt1, rpos1;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_addr, clr_addr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;
  seq_stat_t           stat;

  // out-of-range register values are clamped
  always_comb begin
    if (buf_len_r == '0) begin
      len = CFG_W'(1);
    end else if (buf_len_r > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = buf_len_r;
    end
    if (hop_len_r == '0) begin
      hop = CFG_W'(1);
    end else if (hop_len_r > len) begin
      hop = len;
    end else begin
      hop = hop_len_r;
    end
    wlen = (wr_vlen_r == '0) ? CFG_W'(1) : wr_vlen_r;
    rlen = (rd_vlen_r == '0) ? CFG_W'(1) : rd_vlen_r;
  end

  assign len_wr = cfg_we && (reg_idx_t'(cfg_index) == REG_BUF_LEN);

  // handshake: the ram stage only advances into a free or draining output
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stat.busy && (!s1_valid_r || !out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign is_rd     = (op_t'(in_tuser) == OP_READ);

  // address generation: slide at a vector start when at the buffer end
  always_comb begin
    slide     = (wcnt_r == '0) && (wpos_r >= len);
    base_sum  = {1'b0, rb_r} + {1'b0, hop};
    base_slid = (base_sum >= {1'b0, len}) ? base_sum[CFG_W-1:0] - len
                                          : base_sum[CFG_W-1:0];
    wbase     = slide ? base_slid : rb_r;
    wpos1     = slide ? (wpos_r - hop) : wpos_r;
    do_wr     = (wpos1 < len);
    do_rd     = (rpos_r < len);
    base_sel  = is_rd ? rb_r : wbase;
    pos_sel   = is_rd ? rpos_r : wpos1;
    // both terms below the length, so one conditional subtract wraps it
    phys_sum  = {1'b0, base_sel} + {1'b0, pos_sel};
    phys      = (phys_sum >= {1'b0, len}) ? phys_sum[CFG_W-1:0] - len
                                          : phys_sum[CFG_W-1:0];
    wcnt1     = wcnt_r + 1'b1;
    rcnt1     = rcnt_r + 1'b1;
    rpos1     = do_rd ? (rpos_r + 1'b1) : rpos_r;
  end

  // ram port: clearing sweep, sample write, zero-mode clear or read
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = in_tdata;
    ram_addr  = AW'(phys);
    if (stat.clr_we) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
      ram_addr  = clr_addr;
    end else if (accept) begin
      if (!is_rd) begin
        ram_we = do_wr;
      end else if (zero_mode_r) begin
        ram_we    = do_rd;
        ram_wdata = '0;
      end else begin
        ram_re = do_rd;
      end
    end
  end

  orb_ram #(
    .W     (SAMPLE_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  orb_seq #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .len_wr   (len_wr),
    .raw_base (raw_base_r),
    .len      (len),
    .clr_addr (clr_addr),
    .stat     (stat)
  );

  // configuration and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_len_r   <= RST_LEN;
      hop_len_r   <= RST_LEN;
      zero_mode_r <= 1'b0;
      wr_vlen_r   <= RST_LEN;
      rd_vlen_r   <= RST_LEN;
      raw_base_r  <= '0;
      rb_r        <= '0;
      wpos_r      <= RST_LEN;
      rpos_r      <= '0;
      wcnt_r      <= '0;
      rcnt_r      <= '0;
    end else begin
      if (stat.mod_done) begin
        rb_r <= stat.mod_rem;
      end
      if (accept) begin
        if (!is_rd) begin
          if (slide) begin
            raw_base_r <= base_slid;
            rb_r       <= base_slid;
          end
          wpos_r <= do_wr ? (wpos1 + 1'b1) : wpos1;
          wcnt_r <= (wcnt1 >= wlen) ? '0 : wcnt1;
        end else begin
          if (rcnt1 >= rlen) begin
            rcnt_r <= '0;
            rpos_r <= (rpos1 >= len) ? '0 : rpos1;
          end else begin
            rcnt_r <= rcnt1;
            rpos_r <= rpos1;
          end
        end
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_BUF_LEN:   buf_len_r   <= cfg_wdata;
          REG_HOP_LEN:   hop_len_r   <= cfg_wdata;
          REG_WR_START: begin
            wpos_r <= cfg_wdata;
            wcnt_r <= '0;
          end
          REG_ZERO_MODE: zero_mode_r <= cfg_wdata[0];
          REG_WR_VLEN:   wr_vlen_r   <= cfg_wdata;
          REG_RD_VLEN:   rd_vlen_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // ram stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd_r  <= is_rd;
      s1_ram_r <= is_rd && do_rd && !zero_mode_r;
    end
    if (s1_go) begin
      out_rd_r   <= s1_rd_r;
      out_data_r <= s1_ram_r ? ram_rdata : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_rd_r;

`ifndef SYNTH
  // no transfer while the ram is cleared or the base is reduced
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !in_tready)
    else $error("input accepted while sequencer busy");

  // a ram read always lands in the ram stage
  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> (s1_valid_r && s1_ram_r))
    else $error("ram read without ram stage");

  // reduced base stays inside the window whenever items may enter
  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.busy |-> (rb_r < len))
    else $error("window base outside buffer length");

  // a stalled ram stage keeps its read data
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> $stable(ram_rdata))
    else $error("ram data lost during stall");
`endif

endmodule

`default_nettype wire

### hdl/orb_ram.sv
// ----------------------------------------------------------------------------
// orb_ram
// generic single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module orb_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [W-1:0]             wdata,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/orb_seq.sv
// ----------------------------------------------------------------------------
// orb_seq
// clearing sweep after reset and base re-reduction after a length change
// ----------------------------------------------------------------------------
`default_nettype none

module orb_seq
  import orb_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           len_wr,
  input  wire logic [CFG_W-1:0]               raw_base,
  input  wire logic [CFG_W-1:0]               len,
  output logic      [$clog2(MAX_ENTRIES)-1:0] clr_addr,
  output seq_stat_t                           stat
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(MAX_ENTRIES - 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CFG_W - 1);

  seq_state_t       state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CFG_W-1:0] rem_r, rem_nxt;
  logic [CFG_W-1:0] div_r, div_nxt;
  logic [CFG_W:0]   rem_t;
  logic [CFG_W:0]   rem_s;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_t = {rem_r, div_r[CFG_W-1]};
    rem_s = (rem_t >= {1'b0, len}) ? (rem_t - {1'b0, len}) : rem_t;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    div_nxt      = div_r;
    stat         = '0;
    case (state_r)
      ST_CLEAR: begin
        stat.busy    = 1'b1;
        stat.clr_we  = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (len_wr) begin
          state_nxt = ST_MOD;
          cnt_nxt   = '0;
          rem_nxt   = '0;
          div_nxt   = raw_base;
        end
      end
      ST_MOD: begin
        stat.busy = 1'b1;
        rem_nxt   = rem_s[CFG_W-1:0];
        div_nxt   = {div_r[CFG_W-2:0], 1'b0};
        cnt_nxt   = cnt_r + 1'b1;
        if (len_wr) begin
          cnt_nxt = '0;
          rem_nxt = '0;
          div_nxt = raw_base;
        end else if (cnt_r == LAST_STEP) begin
          stat.mod_done = 1'b1;
          state_nxt     = ST_RUN;
        end
        stat.mod_rem = rem_s[CFG_W-1:0];
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign clr_addr = clr_addr_r;

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the overlap reblocking buffer: a behavioural
// predictor of the window slide, circular base addressing, zero mode and
// read wrap runs beside the block, and every result transfer is compared
// with the oldest prediction, mostly under random gaps and stalls on both streams
// ----------------------------------------------------------------------------

module testbench;
  import orb_pkg::*;

  localparam int DEPTH   = 1024;
  localparam int DEPTH_W = $clog2(DEPTH);

  // one result transfer as the block should produce it
  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                is_read;
  } sample_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata;   // [31:0] in_sample
  logic                in_tuser;   // [0] op
  logic                out_tvalid;
  logic                out_tready;
  logic [SAMPLE_W-1:0] out_tdata;  // [31:0] out_sample
  logic                out_tuser;  // [0] is_read
  logic                cfg_we;
  logic [IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]    cfg_wdata;

  // predicted results still to arrive, oldest first
  sample_result_t awaited_results[$];
  int             mismatch_count;

  // stall control: sender gaps, receiver bursts and a long receiver hold-off
  bit tx_gaps;
  bit rx_stalls;
  int rx_hold;
  int rx_burst;

  // predictor copy of the sample store, window pointers and registers
  logic [SAMPLE_W-1:0] window_ram [DEPTH];
  int unsigned         window_base;
  int unsigned         wr_pos;
  int unsigned         rd_pos;
  int unsigned         wr_cnt;
  int unsigned         rd_cnt;
  logic [CFG_W-1:0]    buf_len_reg;
  logic [CFG_W-1:0]    hop_len_reg;
  logic                zero_mode_reg;
  logic [CFG_W-1:0]    wr_vlen_reg;
  logic [CFG_W-1:0]    rd_vlen_reg;

  overlap_reblock_buffer #(
    .MAX_ENTRIES(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous fixed limit, far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // buffer length in use: zero acts as one, above the depth acts as the depth
  function automatic int unsigned active_len();
    if (buf_len_reg == '0) return 1;
    if (32'(buf_len_reg) > DEPTH) return DEPTH;
    return 32'(buf_len_reg);
  endfunction

  // advances the window state by one transfer and returns the result it causes
  function automatic sample_result_t reblock_predict(op_t op, logic [SAMPLE_W-1:0] word);
    sample_result_t     res;
    int unsigned        len;
    int unsigned        hop;
    int unsigned        vlen;
    logic [DEPTH_W-1:0] slot;
    len         = active_len();
    res.sample  = '0;
    res.is_read = (op == OP_READ);
    if (op == OP_WRITE) begin
      vlen = (wr_vlen_reg == '0) ? 1 : 32'(wr_vlen_reg);
      // slide at a vector start once the write position reached the end
      if (wr_cnt == 0 && wr_pos >= len) begin
        hop = (hop_len_reg == '0) ? 1 : 32'(hop_len_reg);
        if (hop > len) hop = len;
        window_base = (window_base + hop) % len;
        wr_pos      = wr_pos - hop;
      end
      // still past the end: nothing stored, position holds
      if (wr_pos < len) begin
        slot             = DEPTH_W'((window_base + wr_pos) % len);
        window_ram[slot] = word;
        wr_pos++;
      end
      wr_cnt++;
      if (wr_cnt >= vlen) wr_cnt = 0;
    end else begin
      vlen = (rd_vlen_reg == '0) ? 1 : 32'(rd_vlen_reg);
      // past the end the read returns zero and touches nothing
      if (rd_pos < len) begin
        slot = DEPTH_W'((window_base + rd_pos) % len);
        if (zero_mode_reg) window_ram[slot] = '0;
        res.sample = window_ram[slot];
        rd_pos++;
      end
      rd_cnt++;
      // wrap only at a block end
      if (rd_cnt >= vlen) begin
        rd_cnt = 0;
        if (rd_pos >= len) rd_pos = 0;
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // shared stimulus tasks
  // --------------------------------------------------------------------------

  // one register write, only while nothing is in flight
  task automatic cfg_write(reg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BUF_LEN:   buf_len_reg = value;
      REG_HOP_LEN:   hop_len_reg = value;
      REG_WR_START: begin
        wr_pos = 32'(value);
        wr_cnt = 0;
      end
      REG_ZERO_MODE: zero_mode_reg = value[0];
      REG_WR_VLEN:   wr_vlen_reg = value;
      REG_RD_VLEN:   rd_vlen_reg = value;
      default: ;
    endcase
  endtask

  // offers one item and holds it until the transfer; valid stays high afterwards
  task automatic send_sample(op_t op, logic [SAMPLE_W-1:0] word);
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    awaited_results.push_back(reblock_predict(op, word));
  endtask

  // sender pauses until every predicted result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    // output register plus ram stage, with margin
    repeat (4) @(posedge clk);
  endtask

  task automatic send_run(op_t op, int count);
    for (int k = 0; k < count; k++) send_sample(op, $urandom());
  endtask

  // mostly short lengths, now and then the edges of the register range
  function automatic logic [CFG_W-1:0] pick_len();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 11'd2047;
      2:       return 11'd1024;
      3:       return 11'd1;
      default: return CFG_W'($urandom_range(2, 24));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // test tasks
  // --------------------------------------------------------------------------

  // slide on a short window, write past the end, a read block that wraps,
  // extreme sample words
  task automatic test_window_slide();
    cfg_write(REG_HOP_LEN, 11'd2);
    cfg_write(REG_WR_START, 11'd4);
    cfg_write(REG_ZERO_MODE, 11'd0);
    cfg_write(REG_WR_VLEN, 11'd4);
    cfg_write(REG_RD_VLEN, 11'd4);
    cfg_write(REG_BUF_LEN, 11'd4);
    send_sample(OP_WRITE, 32'h0000_0000);
    send_sample(OP_WRITE, 32'hFFFF_FFFF);
    send_sample(OP_WRITE, 32'h8000_0000);
    send_sample(OP_WRITE, 32'h0000_0001);
    send_run(OP_READ, 4);
    send_sample(OP_WRITE, 32'h5555_AAAA);
    send_sample(OP_WRITE, 32'hAAAA_5555);
    drain();
  endtask

  // zero mode reads clear their entries, then normal reads take the next entries
  task automatic test_zero_mode();
    cfg_write(REG_ZERO_MODE, 11'd1);
    send_run(OP_READ, 2);
    drain();
    cfg_write(REG_ZERO_MODE, 11'd0);
    send_run(OP_READ, 2);
    drain();
  endtask

  // register values outside the useful range, read past the end
  task automatic test_register_range();
    cfg_write(REG_HOP_LEN, 11'd0);
    cfg_write(REG_WR_VLEN, 11'd0);
    cfg_write(REG_RD_VLEN, 11'd2);
    cfg_write(REG_WR_START, 11'd2047);
    cfg_write(REG_BUF_LEN, 11'd0);
    send_sample(OP_WRITE, 32'h1234_5678);
    send_run(OP_READ, 2);
    drain();
    cfg_write(REG_RD_VLEN, 11'd0);
    send_sample(OP_READ, 32'h0);
    drain();
    cfg_write(REG_HOP_LEN, 11'd2047);
    cfg_write(REG_WR_START, 11'd1024);
    cfg_write(REG_BUF_LEN, 11'd2047);
    send_sample(OP_WRITE, 32'hDEAD_BEEF);
    drain();
  endtask

  // vector length shrunk below the running count ends the vector next write
  task automatic test_vector_shrink();
    cfg_write(REG_WR_VLEN, 11'd8);
    cfg_write(REG_WR_START, 11'd0);
    cfg_write(REG_HOP_LEN, 11'd4);
    cfg_write(REG_BUF_LEN, 11'd16);
    send_run(OP_WRITE, 5);
    drain();
    cfg_write(REG_WR_VLEN, 11'd3);
    send_sample(OP_WRITE, 32'h0F0F_F0F0);
    drain();
  endtask

  // phases of random settings, mostly whole vectors and read blocks
  task automatic test_random_streams(int phases, int per_phase);
    int budget;
    int run;
    for (int ph = 0; ph < phases; ph++) begin
      drain();
      cfg_write(REG_HOP_LEN, pick_len());
      cfg_write(REG_ZERO_MODE, ($urandom_range(0, 3) == 0) ? 11'd1 : 11'd0);
      cfg_write(REG_WR_VLEN, pick_len());
      cfg_write(REG_RD_VLEN, pick_len());
      if ($urandom_range(0, 1) == 0)
        cfg_write(REG_WR_START, ($urandom_range(0, 7) == 0) ? 11'd2047 : pick_len());
      // buffer length last: its write starts the base reduction
      if ($urandom_range(0, 3) != 0) cfg_write(REG_BUF_LEN, pick_len());
      budget = per_phase;
      while (budget > 0) begin
        if ($urandom_range(0, 7) == 0) begin
          // noise: a single transfer of either kind
          send_sample(op_t'($urandom_range(0, 1)), $urandom());
          budget--;
        end else if ($urandom_range(0, 1) == 0) begin
          run = (wr_vlen_reg == '0) ? 1 : int'(wr_vlen_reg);
          if (run > 40) run = 40;
          if (run > budget) run = budget;
          send_run(OP_WRITE, run);
          budget -= run;
        end else begin
          run = (rd_vlen_reg == '0) ? 1 : int'(rd_vlen_reg);
          if (run > 40) run = 40;
          if (run > budget) run = budget;
          send_run(OP_READ, run);
          budget -= run;
        end
        // sender now and then waits for every result mid-phase
        if ($urandom_range(0, 15) == 0) drain();
      end
    end
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_hold();
    drain();
    cfg_write(REG_WR_VLEN, 11'd8);
    cfg_write(REG_RD_VLEN, 11'd8);
    cfg_write(REG_ZERO_MODE, 11'd0);
    cfg_write(REG_HOP_LEN, 11'd8);
    cfg_write(REG_BUF_LEN, 11'd16);
    rx_hold = 300;
    for (int k = 0; k < 6; k++) begin
      send_run(OP_WRITE, 8);
      send_run(OP_READ, 8);
    end
    drain();
  endtask

  // closing stretch at full rate: no gaps and no stalls
  task automatic test_full_rate();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    test_random_streams(2, 100);
    drain();
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stall bursts and the long hold-off, counted here
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold--;
    end else if (rx_burst > 0) begin
      out_tready <= 1'b0;
      rx_burst--;
    end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      rx_burst = $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // checker: every result transfer against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    sample_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result transfer with nothing awaited: sample %h is_read %b",
                 $realtime, out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_tdata !== want.sample) begin
          $display("%0t: out_sample expected %h actual %h", $realtime, want.sample,
                   out_tdata);
          mismatch_count++;
        end
        if (out_tuser !== want.is_read) begin
          $display("%0t: is_read expected %b actual %b", $realtime, want.is_read,
                   out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= OP_WRITE;
    out_tready <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_BUF_LEN;
    cfg_wdata  <= '0;
    mismatch_count = 0;
    tx_gaps        = 1'b1;
    rx_stalls      = 1'b1;
    rx_hold        = 0;
    rx_burst       = 0;
    // predictor state as after reset
    foreach (window_ram[i]) window_ram[i] = '0;
    buf_len_reg   = RST_LEN;
    hop_len_reg   = RST_LEN;
    zero_mode_reg = 1'b0;
    wr_vlen_reg   = RST_LEN;
    rd_vlen_reg   = RST_LEN;
    window_base   = 0;
    wr_pos        = 32'(RST_LEN);
    rd_pos        = 0;
    wr_cnt        = 0;
    rd_cnt        = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // the clearing pass after reset keeps in_tready low; sends wait for it
    test_window_slide();
    test_zero_mode();
    test_register_range();
    test_vector_shrink();
    test_random_streams(12, 100);
    test_output_hold();
    test_full_rate();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
